// ----- rtl/core/swrl_pkg.sv -----
// Shared types and constants for the sliding window rate limiter.
// Holds the field widths, register indexes, controller states and the
// command and status words passed between the controller and the datapath.
package swrl_pkg;

    // Ring and counter sizing.
    localparam int MAX_BUCKETS = 64;
    localparam int COUNT_BITS  = 32;

    // Fixed field widths.
    localparam int TIME_W      = 40;
    localparam int WIN_W       = 32;
    localparam int BKT_W       = 32;
    localparam int CFG_N_W     = 7;
    localparam int MAXC_W      = 31;
    localparam int TOTAL_OUT_W = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;

    // Shared divider width.
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Derived ring widths.
    localparam int NB_W   = $clog2(MAX_BUCKETS + 1);
    localparam int IDX_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CMP_W  = ((CFG_N_W > NB_W) ? CFG_N_W : NB_W) + 1;
    localparam int CMPT_W = (COUNT_BITS > MAXC_W) ? COUNT_BITS : MAXC_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BKT_COUNT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = CFG_IDX_W'(3);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SWEEP,
        ST_READ,
        ST_COUNT,
        ST_FINISH
    } swrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_start;
        logic div_sel;
        logic take_q;
        logic take_r;
        logic clear_step;
        logic rd_cur;
        logic count;
        logic load_out;
    } swrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic disabled;
        logic restart;
        logic advance;
        logic div_done;
        logic clr_done;
        logic out_free;
    } swrl_sts_t;

endpackage

// ----- rtl/core/sliding_window_rate_limiter.sv -----
// Sliding window rate limiter, top level. Depends on swrl_pkg, swrl_ctrl, swrl_datapath.
// In the same bucket or on a window restart a request reads and counts the current bucket;
// when limiting is disabled the result is passed on directly. A ring advance first divides
// the elapsed time by the bucket length for the move count, then sweeps the entered buckets
// while a second division reduces it modulo the buckets in use. Requests go one at a time.
// Reset clears the control and window state and the ring valid bits at once; no clearing pass.
module sliding_window_rate_limiter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [swrl_pkg::TIME_W-1:0]         now_us,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                restricted,
    output logic [swrl_pkg::TOTAL_OUT_W-1:0]    window_total,
    input  logic                                cfg_wr_en,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    swrl_pkg::swrl_cmd_t cmd;
    swrl_pkg::swrl_sts_t sts;

    // Request sequencer.
    swrl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Window state, bucket ring and result path.
    swrl_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .now_us       (now_us),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .restricted   (restricted),
        .window_total (window_total)
    );

endmodule

// ----- rtl/core/swrl_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on swrl_pkg for the operand width.
module swrl_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [swrl_pkg::DIV_W-1:0] dividend,
    input  logic [swrl_pkg::DIV_W-1:0] divisor,
    output logic [swrl_pkg::DIV_W-1:0] quotient,
    output logic [swrl_pkg::DIV_W-1:0] remainder,
    output logic                       done
);

    logic [swrl_pkg::DIV_W-1:0]     quo_reg;
    logic [swrl_pkg::DIV_W-1:0]     rem_reg;
    logic [swrl_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [swrl_pkg::DIV_W:0]       trial;
    logic [swrl_pkg::DIV_W:0]       diff;
    logic                           fits;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    assign trial = {rem_reg, quo_reg[swrl_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    // Control: iteration count, busy and a done level held until the next start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + swrl_pkg::DIV_CNT_W'(1);
            if (cnt_reg == swrl_pkg::DIV_CNT_W'(swrl_pkg::DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: quotient shifts in from the bottom as the dividend shifts out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[swrl_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? diff[swrl_pkg::DIV_W-1:0] : trial[swrl_pkg::DIV_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- rtl/core/swrl_datapath.sv -----
// Datapath of the rate limiter: configuration registers, window state,
// bucket counter memory with valid bits, shared divider and result registers.
// Depends on swrl_pkg and swrl_div.
module swrl_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  swrl_pkg::swrl_cmd_t                 cmd,
    output swrl_pkg::swrl_sts_t                 sts,
    input  logic                                cfg_wr_en,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [swrl_pkg::TIME_W-1:0]         now_us,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                restricted,
    output logic [swrl_pkg::TOTAL_OUT_W-1:0]    window_total
);

    // Configuration registers.
    logic [swrl_pkg::WIN_W-1:0]   win_reg;
    logic [swrl_pkg::BKT_W-1:0]   bkt_reg;
    logic [swrl_pkg::CFG_N_W-1:0] nbkt_reg;
    logic [swrl_pkg::MAXC_W-1:0]  maxc_reg;

    // Window state.
    logic [swrl_pkg::TIME_W-1:0]     now_reg;
    logic [swrl_pkg::TIME_W-1:0]     start_reg;
    logic [swrl_pkg::IDX_W-1:0]      cur_reg;
    logic [swrl_pkg::COUNT_BITS-1:0] total_reg;
    logic [swrl_pkg::MAX_BUCKETS-1:0] valid_reg;

    // Bucket counter memory and its registered read port.
    logic [swrl_pkg::COUNT_BITS-1:0] cnt_mem [swrl_pkg::MAX_BUCKETS];
    logic [swrl_pkg::COUNT_BITS-1:0] rd_data_reg;
    logic                            rd_vld_reg;
    logic [swrl_pkg::IDX_W-1:0]      rd_addr;

    // Sweep state.
    logic [swrl_pkg::NB_W-1:0]  clr_cnt_reg;
    logic [swrl_pkg::IDX_W-1:0] clr_idx_reg;
    logic                       sub_pend_reg;

    // Result and output registers.
    logic                            res_restricted_reg;
    logic [swrl_pkg::COUNT_BITS-1:0] res_total_reg;
    logic                            out_valid_reg;
    logic                            restricted_reg;
    logic [swrl_pkg::TOTAL_OUT_W-1:0] window_total_reg;

    // Combinational terms.
    logic                            wipe;
    logic [swrl_pkg::NB_W-1:0]       n_eff;
    logic                            enabled;
    logic [swrl_pkg::TIME_W:0]       diff;
    logic [swrl_pkg::TIME_W-1:0]     elapsed;
    logic                            restart;
    logic                            advance;
    logic [swrl_pkg::DIV_W-1:0]      div_dividend;
    logic [swrl_pkg::DIV_W-1:0]      div_divisor;
    logic [swrl_pkg::DIV_W-1:0]      div_quo;
    logic [swrl_pkg::DIV_W-1:0]      div_rem;
    logic                            div_done;
    logic                            step_en;
    logic [swrl_pkg::CMP_W-1:0]      step_inc;
    logic [swrl_pkg::IDX_W-1:0]      step_nxt;
    logic [swrl_pkg::CMP_W-1:0]      idx_sum;
    logic [swrl_pkg::CMP_W-1:0]      idx_wrap;
    logic                            cur_out;
    logic [swrl_pkg::COUNT_BITS-1:0] bkt_val;
    logic [swrl_pkg::COUNT_BITS-1:0] bkt_inc;
    logic [swrl_pkg::COUNT_BITS-1:0] total_inc;
    logic [swrl_pkg::COUNT_BITS-1:0] total_sub;
    logic                            refuse;
    logic                            out_free;

    // A register write or a window restart clears the whole ring.
    assign wipe = cfg_wr_en || (cmd.eval && enabled && restart);

    // Buckets in use, limited to the size of the ring.
    assign n_eff = (swrl_pkg::CMP_W'(nbkt_reg) > swrl_pkg::CMP_W'(swrl_pkg::MAX_BUCKETS))
                 ? swrl_pkg::NB_W'(swrl_pkg::MAX_BUCKETS) : swrl_pkg::NB_W'(nbkt_reg);

    assign enabled = (win_reg != '0) && (bkt_reg != '0) && (n_eff != '0) && (maxc_reg != '0);

    // Elapsed time; the borrow bit flags a request before the window start.
    assign diff    = {1'b0, now_reg} - {1'b0, start_reg};
    assign elapsed = diff[swrl_pkg::TIME_W-1:0];
    assign restart = diff[swrl_pkg::TIME_W] || (elapsed >= swrl_pkg::TIME_W'(win_reg));
    assign advance = elapsed > swrl_pkg::TIME_W'(bkt_reg);

    // The divider first yields elapsed / bucket length, then moves mod buckets in use.
    assign div_dividend = cmd.div_sel ? div_quo : elapsed[swrl_pkg::DIV_W-1:0];
    assign div_divisor  = cmd.div_sel ? swrl_pkg::DIV_W'(n_eff) : swrl_pkg::DIV_W'(bkt_reg);

    swrl_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Sweep step: move to the next slot of the ring and retire it.
    assign step_en  = cmd.clear_step && (clr_cnt_reg != '0);
    assign step_inc = swrl_pkg::CMP_W'(clr_idx_reg) + swrl_pkg::CMP_W'(1);
    assign step_nxt = (step_inc >= swrl_pkg::CMP_W'(n_eff))
                    ? '0 : swrl_pkg::IDX_W'(step_inc);

    // Final index is the start index plus the move count modulo the buckets in use, wrapped once.
    assign idx_sum  = swrl_pkg::CMP_W'(cur_reg) + swrl_pkg::CMP_W'(div_rem);
    assign idx_wrap = (idx_sum >= swrl_pkg::CMP_W'(n_eff))
                    ? idx_sum - swrl_pkg::CMP_W'(n_eff) : idx_sum;
    assign cur_out  = swrl_pkg::CMP_W'(cur_reg) >= swrl_pkg::CMP_W'(n_eff);

    // Bucket value as read; an entry without its valid bit reads as zero.
    assign bkt_val   = rd_vld_reg ? rd_data_reg : '0;
    assign bkt_inc   = (bkt_val == '1) ? bkt_val : bkt_val + swrl_pkg::COUNT_BITS'(1);
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + swrl_pkg::COUNT_BITS'(1);
    assign total_sub = (bkt_val > total_reg) ? '0 : total_reg - bkt_val;
    assign refuse    = swrl_pkg::CMPT_W'(total_reg) > swrl_pkg::CMPT_W'(maxc_reg);

    assign rd_addr  = step_en ? step_nxt : cur_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            bkt_reg  <= '0;
            nbkt_reg <= '0;
            maxc_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                swrl_pkg::REG_WINDOW:    win_reg  <= swrl_pkg::WIN_W'(cfg_data);
                swrl_pkg::REG_BUCKET:    bkt_reg  <= swrl_pkg::BKT_W'(cfg_data);
                swrl_pkg::REG_BKT_COUNT: nbkt_reg <= swrl_pkg::CFG_N_W'(cfg_data);
                swrl_pkg::REG_MAX_COUNT: maxc_reg <= swrl_pkg::MAXC_W'(cfg_data);
            endcase
        end
    end

    // Window start time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cmd.eval && enabled && restart)
        begin
            start_reg <= now_reg;
        end
        else if (cmd.take_q)
        begin
            start_reg <= now_reg - swrl_pkg::TIME_W'(div_rem);
        end
    end

    // Current bucket index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else if (wipe)
        begin
            cur_reg <= '0;
        end
        else if (cmd.eval && enabled && cur_out)
        begin
            cur_reg <= '0;
        end
        else if (cmd.take_r)
        begin
            cur_reg <= swrl_pkg::IDX_W'(idx_wrap);
        end
    end

    // Running total: retired buckets come out, admitted requests go in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (wipe)
        begin
            total_reg <= '0;
        end
        else if (sub_pend_reg)
        begin
            total_reg <= total_sub;
        end
        else if (cmd.count && !refuse)
        begin
            total_reg <= total_inc;
        end
    end

    // Bucket valid bits: cleared together on a wipe, one at a time by the sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wipe)
        begin
            valid_reg <= '0;
        end
        else if (step_en)
        begin
            valid_reg[step_nxt] <= 1'b0;
        end
        else if (cmd.count && !refuse)
        begin
            valid_reg[cur_reg] <= 1'b1;
        end
    end

    // Sweep counter and pending subtract.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            sub_pend_reg <= 1'b0;
        end
        else
        begin
            sub_pend_reg <= step_en;
            if (cmd.take_q)
            begin
                clr_cnt_reg <= (div_quo < swrl_pkg::DIV_W'(n_eff))
                             ? swrl_pkg::NB_W'(div_quo) : n_eff;
            end
            else if (step_en)
            begin
                clr_cnt_reg <= clr_cnt_reg - swrl_pkg::NB_W'(1);
            end
        end
    end

    // Request time and sweep position.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            now_reg <= now_us;
        end
        if (cmd.take_q)
        begin
            clr_idx_reg <= cur_reg;
        end
        else if (step_en)
        begin
            clr_idx_reg <= step_nxt;
        end
    end

    // Bucket memory: one write port for the count, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.count && !refuse)
        begin
            cnt_mem[cur_reg] <= bkt_inc;
        end
        if (step_en || cmd.rd_cur)
        begin
            rd_data_reg <= cnt_mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

    // Result of the current request.
    always_ff @(posedge clk)
    begin
        if (cmd.eval && !enabled)
        begin
            res_restricted_reg <= 1'b0;
            res_total_reg      <= total_reg;
        end
        else if (cmd.count)
        begin
            res_restricted_reg <= refuse;
            res_total_reg      <= refuse ? total_reg : total_inc;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            restricted_reg   <= res_restricted_reg;
            window_total_reg <= swrl_pkg::TOTAL_OUT_W'(res_total_reg);
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts.disabled = !enabled;
        sts.restart  = restart;
        sts.advance  = advance;
        sts.div_done = div_done;
        sts.clr_done = (clr_cnt_reg == '0);
        sts.out_free = out_free;
    end

    assign out_valid    = out_valid_reg;
    assign restricted   = restricted_reg;
    assign window_total = window_total_reg;

endmodule

// ----- rtl/core/swrl_ctrl.sv -----
// Controller state machine of the rate limiter.
// Sequences one request at a time; depends on swrl_pkg for states and command words.
module swrl_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  swrl_pkg::swrl_sts_t sts,
    output swrl_pkg::swrl_cmd_t cmd
);

    swrl_pkg::swrl_state_t state_reg;
    swrl_pkg::swrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swrl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            swrl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = swrl_pkg::ST_EVAL;
                end
            end
            swrl_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (sts.disabled)
                begin
                    state_next = swrl_pkg::ST_FINISH;
                end
                else if (sts.restart)
                begin
                    state_next = swrl_pkg::ST_READ;
                end
                else if (sts.advance)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = swrl_pkg::ST_DIV;
                end
                else
                begin
                    state_next = swrl_pkg::ST_READ;
                end
            end
            swrl_pkg::ST_DIV:
            begin
                // Take the move count, then divide it by the buckets in use
                // while the sweep retires the entered slots.
                if (sts.div_done)
                begin
                    cmd.take_q    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b1;
                    state_next    = swrl_pkg::ST_SWEEP;
                end
            end
            swrl_pkg::ST_SWEEP:
            begin
                cmd.clear_step = 1'b1;
                cmd.div_sel    = 1'b1;
                if (sts.clr_done && sts.div_done)
                begin
                    cmd.take_r = 1'b1;
                    state_next = swrl_pkg::ST_READ;
                end
            end
            swrl_pkg::ST_READ:
            begin
                cmd.rd_cur = 1'b1;
                state_next = swrl_pkg::ST_COUNT;
            end
            swrl_pkg::ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = swrl_pkg::ST_FINISH;
            end
            swrl_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = swrl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swrl_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != swrl_pkg::ST_IDLE);

endmodule
